>>> design/positional_list_store_defines.svh
// Assertion helpers used by positional_list_store.
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PLS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pls check failed");

// Next-cycle implication, checked outside reset.
`define PLS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pls check failed");

`endif

>>> design/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Types and constants for the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int PLS_CAPACITY = 16;
    localparam int PLS_WORD_W   = 32;
    localparam int PLS_FIELD_W  = 5;

    typedef enum logic [2:0] {
        REQ_INS_HEAD = 3'd0,
        REQ_INS_TAIL = 3'd1,
        REQ_INS_POS  = 3'd2,
        REQ_DEL_HEAD = 3'd3,
        REQ_DEL_TAIL = 3'd4,
        REQ_DEL_POS  = 3'd5,
        REQ_DUMP     = 3'd6
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_RESP,
        S_DUMP_RD,
        S_DUMP_OUT
    } t_state;

endpackage

>>> design/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store
// Bounded ordered list of signed 32-bit words with positional insert/delete.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one request word: type,
//   value and 1-based position. Output channel (o_out_valid / i_out_stall)
//   returns result words: status, data, element position, count and last.
//   Every request but a non-empty dump yields one result word with last set;
//   a non-empty dump yields one word per element in list order, last on the
//   final one. o_in_stall is high from acceptance until the final result word
//   is loaded into the output register; one request is in flight at a time.
//   Each cell an insert or delete moves takes a RAM read, then a write; a
//   rejected request goes straight to its result. A dump reads each element
//   from the RAM, then loads it into the output register. All cell moves go
//   through the single RAM port pair and the shared index unit.
//   Reset clears the length to zero and drops any pending result; the cell
//   RAM is not cleared, since only cells below the length are ever read.
//   An output stall holds the result register and the sequencer's result states.
// ----------------------------------------------------------------------------
`include "positional_list_store_defines.svh"

module positional_list_store import pls_pkg::*; #(
    parameter int CAPACITY = PLS_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_req_type,
    input  logic signed [PLS_WORD_W-1:0]  i_value,
    input  logic [PLS_FIELD_W-1:0]        i_position,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic signed [PLS_WORD_W-1:0]  o_data,
    output logic [PLS_FIELD_W-1:0]        o_element_pos,
    output logic [PLS_FIELD_W-1:0]        o_count,
    output logic                          o_last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > PLS_FIELD_W) ? CW : PLS_FIELD_W) + 1;

    t_state                 r_state, n_state;
    logic                   r_ins, n_ins;
    logic [PLS_WORD_W-1:0]  r_value, n_value;
    logic [AW-1:0]          r_idx, n_idx;
    logic [AW-1:0]          r_tgt, n_tgt;
    logic [CW-1:0]          r_len, n_len;
    t_status                r_status, n_status;
    logic                   r_ovalid, n_ovalid;
    t_status                r_o_status, n_o_status;
    logic [PLS_WORD_W-1:0]  r_o_data, n_o_data;
    logic [PLS_FIELD_W-1:0] r_o_pos, n_o_pos;
    logic [PLS_FIELD_W-1:0] r_o_count, n_o_count;
    logic                   r_o_last, n_o_last;

    logic                   in_acc;
    logic                   out_free;
    t_req                   req;
    logic [PW-1:0]          len_ext;
    logic [PW-1:0]          pos_ext;
    logic                   full;
    logic                   empty;
    t_status                dec_status;
    logic                   dec_walk;
    logic                   dec_ins;
    logic [AW-1:0]          dec_idx;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [PLS_WORD_W-1:0]  ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [PLS_WORD_W-1:0]  ram_rdata;
    logic [AW-1:0]          idx_nxt;
    logic                   idx_at;

    pls_ram #(
        .WIDTH (PLS_WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pls_idx #(
        .AW (AW)
    ) u_idx (
        .i_idx  (r_idx),
        .i_tgt  (r_tgt),
        .i_down (r_ins),
        .o_nxt  (idx_nxt),
        .o_at   (idx_at)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_ovalid || !i_out_stall;

    assign req     = t_req'(i_req_type);
    assign len_ext = PW'(r_len);
    assign pos_ext = PW'(i_position);
    assign full    = (r_len == CW'(CAPACITY));
    assign empty   = (r_len == '0);

    // request decode
    always_comb begin
        dec_status = ST_OK;
        dec_walk   = 1'b0;
        dec_ins    = 1'b0;
        dec_idx    = '0;
        case (req)
            REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
                dec_ins = 1'b1;
                if (full) begin
                    dec_status = ST_FULL;
                end else if (req == REQ_INS_HEAD) begin
                    dec_walk = 1'b1;
                end else if (req == REQ_INS_TAIL) begin
                    dec_walk = 1'b1;
                    dec_idx  = r_len[AW-1:0];
                end else if (pos_ext == '0 || pos_ext > len_ext + PW'(1)) begin
                    dec_status = ST_BADPOS;
                end else begin
                    dec_walk = 1'b1;
                    dec_idx  = AW'(pos_ext - PW'(1));
                end
            end
            REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_DEL_POS: begin
                if (empty) begin
                    dec_status = ST_EMPTY;
                end else if (req == REQ_DEL_HEAD) begin
                    dec_walk = 1'b1;
                end else if (req == REQ_DEL_TAIL) begin
                    dec_walk = 1'b1;
                    dec_idx  = AW'(len_ext - PW'(1));
                end else if (pos_ext == '0 || pos_ext > len_ext) begin
                    dec_status = ST_BADPOS;
                end else begin
                    dec_walk = 1'b1;
                    dec_idx  = AW'(pos_ext - PW'(1));
                end
            end
            REQ_DUMP: begin
                if (empty) begin
                    dec_status = ST_EMPTY;
                end else begin
                    dec_walk = 1'b1;
                end
            end
            default: begin
                dec_status = ST_BADPOS;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!dec_walk) begin
                        n_state = S_RESP;
                    end else if (req == REQ_DUMP) begin
                        n_state = S_DUMP_RD;
                    end else begin
                        n_state = S_SHIFT_RD;
                    end
                end
            end
            S_SHIFT_RD: n_state = idx_at ? S_PUT : S_SHIFT_WR;
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_PUT:      n_state = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_DUMP_RD:  n_state = S_DUMP_OUT;
            S_DUMP_OUT: begin
                if (out_free) begin
                    n_state = idx_at ? S_IDLE : S_DUMP_RD;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_ins      = r_ins;
        n_value    = r_value;
        n_idx      = r_idx;
        n_tgt      = r_tgt;
        n_len      = r_len;
        n_status   = r_status;
        n_ovalid   = r_ovalid && i_out_stall;
        n_o_status = r_o_status;
        n_o_data   = r_o_data;
        n_o_pos    = r_o_pos;
        n_o_count  = r_o_count;
        n_o_last   = r_o_last;
        ram_we     = 1'b0;
        ram_waddr  = r_idx;
        ram_wdata  = ram_rdata;
        ram_re     = 1'b0;
        ram_raddr  = idx_nxt;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_ins    = dec_ins;
                    n_value  = i_value;
                    n_status = dec_status;
                    if (dec_ins) begin
                        n_idx = r_len[AW-1:0];
                        n_tgt = dec_idx;
                    end else begin
                        n_idx = dec_idx;
                        n_tgt = AW'(len_ext - PW'(1));
                    end
                end
            end
            S_SHIFT_RD: begin
                ram_re = !idx_at;
            end
            S_SHIFT_WR: begin
                ram_we = 1'b1;
                n_idx  = idx_nxt;
            end
            S_PUT: begin
                if (r_ins) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_value;
                    n_len     = r_len + CW'(1);
                end else begin
                    n_len     = r_len - CW'(1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_data   = '0;
                    n_o_pos    = '0;
                    n_o_count  = len_ext[PLS_FIELD_W-1:0];
                    n_o_last   = 1'b1;
                end
            end
            S_DUMP_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_idx;
            end
            S_DUMP_OUT: begin
                if (out_free) begin
                    n_ovalid   = 1'b1;
                    n_o_status = ST_OK;
                    n_o_data   = ram_rdata;
                    n_o_pos    = PLS_FIELD_W'(PW'(r_idx) + PW'(1));
                    n_o_count  = len_ext[PLS_FIELD_W-1:0];
                    n_o_last   = idx_at;
                    n_idx      = idx_nxt;
                end
            end
            default: begin
                n_ovalid = r_ovalid && i_out_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins      <= n_ins;
        r_value    <= n_value;
        r_idx      <= n_idx;
        r_tgt      <= n_tgt;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_data   <= n_o_data;
        r_o_pos    <= n_o_pos;
        r_o_count  <= n_o_count;
        r_o_last   <= n_o_last;
    end

    assign o_out_valid   = r_ovalid;
    assign o_status      = r_o_status;
    assign o_data        = r_o_data;
    assign o_element_pos = r_o_pos;
    assign o_count       = r_o_count;
    assign o_last        = r_o_last;

    `PLS_ASSERT_IMP(a_len_bound, 1'b1, r_len <= CW'(CAPACITY))
    `PLS_ASSERT_NXT(a_len_only_put, r_state != S_PUT, $stable(r_len))
    `PLS_ASSERT_IMP(a_write_in_list, ram_we, PW'(ram_waddr) <= len_ext)
    `PLS_ASSERT_NXT(a_resp_waits, (r_state == S_RESP) && !out_free, r_state == S_RESP)

endmodule

>>> design/pls_ram.sv
// ----------------------------------------------------------------------------
// pls_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/pls_idx.sv
// ----------------------------------------------------------------------------
// pls_idx
// Shared index unit: steps a cell index up or down and compares it with the
// end index of the current walk.
// ----------------------------------------------------------------------------
module pls_idx #(
    parameter int AW = 4
) (
    input  logic [AW-1:0] i_idx,
    input  logic [AW-1:0] i_tgt,
    input  logic          i_down,
    output logic [AW-1:0] o_nxt,
    output logic          o_at
);

    assign o_nxt = i_down ? (i_idx - AW'(1)) : (i_idx + AW'(1));
    assign o_at  = (i_idx == i_tgt);

endmodule

>>> tb/sv/pls_result_checker.sv
// ----------------------------------------------------------------------------
// pls_result_checker
// Watches both channels of the positional list store. Every accepted request
// is applied to a private copy of the list, which queues the result words it
// should produce. Each accepted result word is compared with the oldest one
// queued, and failures, queued words and the list length are reported.
// ----------------------------------------------------------------------------
module pls_result_checker import pls_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [2:0]                    i_req_type,
    input  logic signed [PLS_WORD_W-1:0]  i_value,
    input  logic [PLS_FIELD_W-1:0]        i_position,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [1:0]                    i_status,
    input  logic signed [PLS_WORD_W-1:0]  i_data,
    input  logic [PLS_FIELD_W-1:0]        i_element_pos,
    input  logic [PLS_FIELD_W-1:0]        i_count,
    input  logic                          i_last,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_words_checked,
    output int                            o_list_len
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_status                      status;
        logic signed [PLS_WORD_W-1:0] data;
        logic [PLS_FIELD_W-1:0]       element_pos;
        logic [PLS_FIELD_W-1:0]       count;
        logic                         last;
    } t_list_word;

    logic signed [PLS_WORD_W-1:0] cells [PLS_CAPACITY];
    int                           list_len = 0;
    int                           fail_count = 0;
    int                           words_checked = 0;
    int                           pending_count = 0;
    t_list_word                   expected_words [$];

    assign o_fail_count    = fail_count;
    assign o_pending       = pending_count;
    assign o_words_checked = words_checked;
    assign o_list_len      = list_len;

    initial begin
        foreach (cells[k]) cells[k] = '0;
    end

    function automatic void queue_word(t_status st, logic signed [PLS_WORD_W-1:0] d,
                                       int epos, logic lst);
        t_list_word w;
        w.status      = st;
        w.data        = d;
        w.element_pos = PLS_FIELD_W'(epos);
        w.count       = PLS_FIELD_W'(list_len);
        w.last        = lst;
        expected_words.push_back(w);
    endfunction

    function automatic void apply_request(logic [2:0] req, logic signed [PLS_WORD_W-1:0] val,
                                          logic [PLS_FIELD_W-1:0] pos);
        t_status st;
        int      idx;
        int      i;
        st  = ST_OK;
        idx = 0;
        case (req)
            REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
                if (list_len >= PLS_CAPACITY) begin
                    st = ST_FULL;
                end else if (req == REQ_INS_HEAD) begin
                    idx = 0;
                end else if (req == REQ_INS_TAIL) begin
                    idx = list_len;
                end else if (pos < 1 || pos > list_len + 1) begin
                    st = ST_BADPOS;
                end else begin
                    idx = pos - 1;
                end
                if (st == ST_OK) begin
                    for (i = list_len; i > idx; i--) cells[i] = cells[i-1];
                    cells[idx] = val;
                    list_len++;
                end
            end
            REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_DEL_POS: begin
                if (list_len == 0) begin
                    st = ST_EMPTY;
                end else if (req == REQ_DEL_HEAD) begin
                    idx = 0;
                end else if (req == REQ_DEL_TAIL) begin
                    idx = list_len - 1;
                end else if (pos < 1 || pos > list_len) begin
                    st = ST_BADPOS;
                end else begin
                    idx = pos - 1;
                end
                if (st == ST_OK) begin
                    for (i = idx; i + 1 < list_len; i++) cells[i] = cells[i+1];
                    list_len--;
                end
            end
            REQ_DUMP: begin
                if (list_len == 0) begin
                    st = ST_EMPTY;
                end
            end
            default: begin
                st = ST_BADPOS;
            end
        endcase
        if (req == REQ_DUMP && list_len != 0) begin
            for (i = 0; i < list_len; i++) begin
                queue_word(ST_OK, cells[i], i + 1, (i + 1 == list_len));
            end
        end else begin
            queue_word(st, '0, 0, 1'b1);
        end
    endfunction

    function automatic void check_word();
        t_list_word w;
        if (expected_words.size() == 0) begin
            $error("unexpected result word: status %0d data %0d pos %0d count %0d last %0b",
                   i_status, i_data, i_element_pos, i_count, i_last);
            fail_count++;
            return;
        end
        w = expected_words.pop_front();
        words_checked++;
        if (i_status !== w.status) begin
            $error("status: expected %0d, actual %0d", w.status, i_status);
            fail_count++;
        end
        if (i_data !== w.data) begin
            $error("data: expected %0d, actual %0d", w.data, i_data);
            fail_count++;
        end
        if (i_element_pos !== w.element_pos) begin
            $error("element_pos: expected %0d, actual %0d", w.element_pos, i_element_pos);
            fail_count++;
        end
        if (i_count !== w.count) begin
            $error("count: expected %0d, actual %0d", w.count, i_count);
            fail_count++;
        end
        if (i_last !== w.last) begin
            $error("last: expected %0b, actual %0b", w.last, i_last);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            expected_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_word();
            if (i_in_valid && !i_in_stall) apply_request(i_req_type, i_value, i_position);
        end
        pending_count = expected_words.size();
    end

endmodule

>>> tb/sv/tb_positional_list_store.sv
// ----------------------------------------------------------------------------
// tb_positional_list_store
// Drives request words into the positional list store: a directed pass over
// empty, full and out-of-range cases, then random traffic that alternates
// between growing and shrinking the list, under several idle/stall mixes and
// one long output hold-off. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_positional_list_store import pls_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REQ_UNUSED  = 3'd7;
    localparam int         HOLD_CYCLES = 400;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [2:0]                    i_req_type = '0;
    logic signed [PLS_WORD_W-1:0]  i_value = '0;
    logic [PLS_FIELD_W-1:0]        i_position = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [1:0]                    o_status;
    logic signed [PLS_WORD_W-1:0]  o_data;
    logic [PLS_FIELD_W-1:0]        o_element_pos;
    logic [PLS_FIELD_W-1:0]        o_count;
    logic                          o_last;

    int fail_count;
    int pending_words;
    int words_checked;
    int list_len;

    int in_idle_pct = 0;
    int out_stall_pct = 0;
    bit hold_off = 1'b0;
    int n_sent = 0;
    int n_random = 0;

    positional_list_store i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_data        (o_data),
        .o_element_pos (o_element_pos),
        .o_count       (o_count),
        .o_last        (o_last)
    );

    pls_result_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_value         (i_value),
        .i_position      (i_position),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_status        (o_status),
        .i_data          (o_data),
        .i_element_pos   (o_element_pos),
        .i_count         (o_count),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending_words),
        .o_words_checked (words_checked),
        .o_list_len      (list_len)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_stall <= hold_off || ($urandom_range(0, 99) < out_stall_pct);
    end

    // hold valid low while a random draw falls under the idle percentage, then land on a falling edge
    task automatic hold_idle();
        while ($urandom_range(0, 99) < in_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
    endtask

    task automatic drive_word(logic [2:0] rt, logic signed [PLS_WORD_W-1:0] v,
                              logic [PLS_FIELD_W-1:0] p);
        i_in_valid <= 1'b1;
        i_req_type <= rt;
        i_value    <= v;
        i_position <= p;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
    endtask

    task automatic offer(logic [2:0] rt, logic signed [PLS_WORD_W-1:0] v,
                         logic [PLS_FIELD_W-1:0] p);
        hold_idle();
        drive_word(rt, v, p);
    endtask

    // grow and shrink the list in alternating windows so full and empty are hit
    task automatic offer_random();
        int                           len;
        int                           roll;
        bit                           growing;
        logic [2:0]                   rt;
        logic signed [PLS_WORD_W-1:0] v;
        logic [PLS_FIELD_W-1:0]       p;
        hold_idle();
        len     = list_len;
        growing = ((n_random / 40) % 2) == 0;
        roll    = $urandom_range(0, 99);
        if (roll < 2) begin
            rt = REQ_UNUSED;
        end else if (roll < 12) begin
            rt = REQ_DUMP;
        end else if (roll < (growing ? 88 : 24)) begin
            rt = 3'($urandom_range(REQ_INS_HEAD, REQ_INS_POS));
        end else begin
            rt = 3'($urandom_range(REQ_DEL_HEAD, REQ_DEL_POS));
        end
        if ($urandom_range(0, 99) < 20) begin
            p = 5'($urandom_range(0, 31));
        end else if (rt == REQ_INS_POS) begin
            p = 5'($urandom_range(1, len + 1));
        end else begin
            p = (len == 0) ? 5'd1 : 5'($urandom_range(1, len));
        end
        case ($urandom_range(0, 19))
            0: v = '0;
            1: v = '1;
            2: v = {1'b0, {(PLS_WORD_W-1){1'b1}}};
            3: v = {1'b1, {(PLS_WORD_W-1){1'b0}}};
            default: v = $urandom;
        endcase
        n_random++;
        drive_word(rt, v, p);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        offer(REQ_DUMP, '0, 5'd0);
        offer(REQ_DEL_HEAD, '0, 5'd0);
        offer(REQ_DEL_TAIL, '0, 5'd0);
        offer(REQ_DEL_POS, '0, 5'd0);
        offer(REQ_INS_POS, 32'sd5, 5'd0);
        offer(REQ_INS_POS, 32'sd6, 5'd2);
        offer(REQ_INS_HEAD, 32'sh7FFF_FFFF, 5'd0);
        offer(REQ_INS_TAIL, 32'sh8000_0000, 5'd31);
        offer(REQ_INS_POS, 32'sd0, 5'd3);
        offer(REQ_INS_POS, -32'sd1, 5'd1);
        offer(REQ_UNUSED, 32'sd7, 5'd1);
        offer(REQ_DUMP, '0, 5'd0);
        offer(REQ_DEL_POS, '0, 5'd0);
        offer(REQ_DEL_POS, '0, 5'd31);
        offer(REQ_DEL_POS, '0, 5'd5);
        offer(REQ_DEL_POS, '0, 5'd2);
        offer(REQ_DEL_TAIL, '0, 5'd0);
        offer(REQ_DEL_HEAD, '0, 5'd0);
        repeat (15) offer(3'($urandom_range(REQ_INS_HEAD, REQ_INS_TAIL)), $urandom, 5'd0);
        offer(REQ_INS_HEAD, 32'sd1, 5'd1);
        offer(REQ_INS_POS, 32'sd2, 5'd31);
        offer(REQ_INS_TAIL, 32'sd3, 5'd0);
        offer(REQ_DUMP, '0, 5'd0);
        offer(REQ_DEL_POS, '0, 5'd17);

        // offer random requests while the output is held off, so they back up behind the held result
        fork
            begin
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (20) offer_random();
        join
        repeat (25) offer_random();

        in_idle_pct = 57;
        out_stall_pct = 0;
        repeat (59) offer_random();
        in_idle_pct = 0;
        out_stall_pct = 57;
        repeat (59) offer_random();
        in_idle_pct = 23;
        out_stall_pct = 23;
        repeat (59) offer_random();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_words != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        if (pending_words != 0) begin
            $error("%0d result words never arrived", pending_words);
        end
        $display("Run covered %0d requests: empty, full, bad-position and unused-code cases,",
                 n_sent);
        $display("four idle/stall mixes and a long output hold-off; %0d result words checked.",
                 words_checked);
        if (fail_count == 0 && pending_words == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/pls_pkg.sv
design/pls_ram.sv
design/pls_idx.sv
design/positional_list_store.sv
tb/sv/pls_result_checker.sv
tb/sv/tb_positional_list_store.sv
